// ===== hw/rtl/icrc_pkg.sv =====
// Shared constants, codes and control types of the IPv4 CIDR redirect classifier.
// No dependencies; imported by the interfaces, icrc_ctrl, icrc_dp and the top level.

package icrc_pkg;

  localparam int SRC_RULES = 32;
  localparam int DST_RULES = 32;
  localparam int QUEUES    = 64;

  localparam int FuncW       = 3;
  localparam int ByteW       = 8;
  localparam int QueueW      = 6;
  localparam int RuleIdxW    = 5;
  localparam int AddrW       = 32;
  localparam int CountW      = 6;
  localparam int SelW        = 3;
  localparam int ReasonW     = 2;
  localparam int CounterW    = 64;
  localparam int NumCounters = 5;
  localparam int CfgIdxW     = 1;
  localparam int PosW        = 6;
  localparam int EthTypeW    = 16;

  localparam int RuleW     = 2 * AddrW;
  localparam int SrcAw     = (SRC_RULES > 1) ? $clog2(SRC_RULES) : 1;
  localparam int DstAw     = (DST_RULES > 1) ? $clog2(DST_RULES) : 1;
  localparam int MaxRules  = (SRC_RULES > DST_RULES) ? SRC_RULES : DST_RULES;
  localparam int RuleCntW  = $clog2(MaxRules + 1);
  localparam int QueueAw   = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam logic [EthTypeW-1:0] EthIpv4 = 16'h0800;
  localparam logic [PosW-1:0] PosMax      = 6'd63;
  localparam logic [PosW-1:0] MinFrameLen = 6'd34;
  localparam logic [PosW-1:0] PosEthHi    = 6'd12;
  localparam logic [PosW-1:0] PosEthLo    = 6'd13;
  localparam logic [PosW-1:0] PosSrcFirst = 6'd26;
  localparam logic [PosW-1:0] PosSrcLast  = 6'd29;
  localparam logic [PosW-1:0] PosDstFirst = 6'd30;
  localparam logic [PosW-1:0] PosDstLast  = 6'd33;

  typedef enum logic [FuncW-1:0] {
    FN_FRAME_BYTE = 3'd0,
    FN_WR_SRC     = 3'd1,
    FN_WR_DST     = 3'd2,
    FN_BIND       = 3'd3,
    FN_READ_CNT   = 3'd4
  } func_e;

  typedef enum logic [ReasonW-1:0] {
    RSN_REDIRECT = 2'd0,
    RSN_NOT_IPV4 = 2'd1,
    RSN_NO_MATCH = 2'd2,
    RSN_UNBOUND  = 2'd3
  } reason_e;

  typedef enum logic [SelW-1:0] {
    CNT_TOTAL     = 3'd0,
    CNT_NOT_IPV4  = 3'd1,
    CNT_NO_MATCH  = 3'd2,
    CNT_NO_SOCKET = 3'd3,
    CNT_REDIRECT  = 3'd4
  } cnt_sel_e;

  typedef enum logic [1:0] {
    V_SHORT   = 2'd0,
    V_NOMATCH = 2'd1,
    V_MATCH   = 2'd2
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_COUNT = 1'b0,
    REG_DST_COUNT = 1'b1
  } reg_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_COUNTER = 1'b1
  } kind_e;

  typedef struct packed {
    logic     capture;
    logic     src_wr;
    logic     dst_wr;
    logic     bind_wr;
    logic     cnt_rd;
    logic     idx_clr;
    logic     idx_inc;
    logic     src_rd;
    logic     dst_rd;
    logic     verdict_ld;
    verdict_e verdict;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic frame_bad;
    logic src_empty;
    logic dst_empty;
    logic src_hit;
    logic dst_hit;
    logic src_last;
    logic dst_last;
  } dp_status_t;

  function automatic cnt_sel_e reason_to_cnt(reason_e r);
    cnt_sel_e c;
    case (r)
      RSN_REDIRECT: c = CNT_REDIRECT;
      RSN_NOT_IPV4: c = CNT_NOT_IPV4;
      RSN_NO_MATCH: c = CNT_NO_MATCH;
      RSN_UNBOUND:  c = CNT_NO_SOCKET;
      default:      c = CNT_NOT_IPV4;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/icrc_in_if.sv =====
// Input channel: frame bytes, rule writes, queue binds and counter reads.
// Depends on icrc_pkg.

interface icrc_in_if;
  import icrc_pkg::*;

  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [ByteW-1:0]    data_byte;
  logic                last_byte;
  logic [QueueW-1:0]   queue_index;
  logic [RuleIdxW-1:0] rule_index;
  logic [AddrW-1:0]    rule_net;
  logic [AddrW-1:0]    rule_mask;
  logic                bind_flag;
  logic [SelW-1:0]     counter_select;

  modport source (
    output valid, func, data_byte, last_byte, queue_index, rule_index,
           rule_net, rule_mask, bind_flag, counter_select,
    input  ready
  );

  modport sink (
    input  valid, func, data_byte, last_byte, queue_index, rule_index,
           rule_net, rule_mask, bind_flag, counter_select,
    output ready
  );
endinterface

// ===== hw/rtl/icrc_out_if.sv =====
// Result channel: frame verdicts and counter read values.
// Depends on icrc_pkg.

interface icrc_out_if;
  import icrc_pkg::*;

  logic                valid;
  logic                ready;
  logic                result_kind;
  logic                redirect;
  logic [QueueW-1:0]   redirect_queue;
  logic [ReasonW-1:0]  reason;
  logic [CounterW-1:0] counter_value;

  modport source (
    output valid, result_kind, redirect, redirect_queue, reason, counter_value,
    input  ready
  );

  modport sink (
    input  valid, result_kind, redirect, redirect_queue, reason, counter_value,
    output ready
  );
endinterface

// ===== hw/rtl/icrc_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on icrc_pkg.

interface icrc_cfg_if;
  import icrc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CountW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/icrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module icrc_ram #(
  parameter  int Width = 64,
  parameter  int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/icrc_ctrl.sv =====
// Controller: decodes input words, sequences the rule scans and the verdict.
// Depends on icrc_pkg; drives icrc_dp through ctrl_cmd_t.

module icrc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  icrc_pkg::func_e        func_i,
  input  logic                   last_i,
  input  icrc_pkg::dp_status_t   sts_i,
  output icrc_pkg::ctrl_cmd_t    cmd_o
);
  import icrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC_RD,
    ST_SRC_CMP,
    ST_DST_RD,
    ST_DST_CMP,
    ST_VERDICT
  } state_e;

  state_e state_q, state_d;
  logic   match_q, match_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    match_d = match_q;
    cmd_o   = '0;
    cmd_o.verdict = V_SHORT;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FN_FRAME_BYTE: begin
              cmd_o.capture = 1'b1;
              if (last_i) begin
                if (sts_i.frame_bad) begin
                  cmd_o.verdict_ld = 1'b1;
                  cmd_o.verdict    = V_SHORT;
                end else begin
                  cmd_o.idx_clr = 1'b1;
                  if (!sts_i.src_empty) begin
                    state_d = ST_SRC_RD;
                  end else if (!sts_i.dst_empty) begin
                    state_d = ST_DST_RD;
                  end else begin
                    match_d = 1'b1;
                    state_d = ST_VERDICT;
                  end
                end
              end
            end
            FN_WR_SRC:   cmd_o.src_wr  = 1'b1;
            FN_WR_DST:   cmd_o.dst_wr  = 1'b1;
            FN_BIND:     cmd_o.bind_wr = 1'b1;
            FN_READ_CNT: cmd_o.cnt_rd  = 1'b1;
            default:     ;
          endcase
        end
      end
      ST_SRC_RD: begin
        cmd_o.src_rd = 1'b1;
        state_d      = ST_SRC_CMP;
      end
      ST_SRC_CMP: begin
        if (sts_i.src_hit) begin
          cmd_o.idx_clr = 1'b1;
          if (sts_i.dst_empty) begin
            match_d = 1'b1;
            state_d = ST_VERDICT;
          end else begin
            state_d = ST_DST_RD;
          end
        end else if (sts_i.src_last) begin
          match_d = 1'b0;
          state_d = ST_VERDICT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_SRC_RD;
        end
      end
      ST_DST_RD: begin
        cmd_o.dst_rd = 1'b1;
        state_d      = ST_DST_CMP;
      end
      ST_DST_CMP: begin
        if (sts_i.dst_hit) begin
          match_d = 1'b1;
          state_d = ST_VERDICT;
        end else if (sts_i.dst_last) begin
          match_d = 1'b0;
          state_d = ST_VERDICT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_DST_RD;
        end
      end
      ST_VERDICT: begin
        if (sts_i.out_free) begin
          cmd_o.verdict_ld = 1'b1;
          cmd_o.verdict    = match_q ? V_MATCH : V_NOMATCH;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      match_q <= 1'b0;
    end else begin
      state_q <= state_d;
      match_q <= match_d;
    end
  end

endmodule

// ===== hw/rtl/icrc_dp.sv =====
// Datapath: header capture, rule RAMs and compare, queue bindings, event
// counters and the result register. Depends on icrc_pkg and icrc_ram.

module icrc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  icrc_pkg::ctrl_cmd_t           cmd_i,
  output icrc_pkg::dp_status_t          sts_o,
  input  logic [icrc_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          last_byte_i,
  input  logic [icrc_pkg::QueueW-1:0]   queue_index_i,
  input  logic [icrc_pkg::RuleIdxW-1:0] rule_index_i,
  input  logic [icrc_pkg::AddrW-1:0]    rule_net_i,
  input  logic [icrc_pkg::AddrW-1:0]    rule_mask_i,
  input  logic                          bind_flag_i,
  input  logic [icrc_pkg::SelW-1:0]     counter_select_i,
  input  logic                          cfg_we_i,
  input  logic [icrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [icrc_pkg::CountW-1:0]   cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          result_kind_o,
  output logic                          redirect_o,
  output logic [icrc_pkg::QueueW-1:0]   redirect_queue_o,
  output logic [icrc_pkg::ReasonW-1:0]  reason_o,
  output logic [icrc_pkg::CounterW-1:0] counter_value_o
);
  import icrc_pkg::*;

  logic [CountW-1:0]   src_count_q, dst_count_q;
  logic [RuleCntW-1:0] src_eff, dst_eff;
  logic [RuleCntW-1:0] idx_q;

  logic [PosW-1:0]     pos_q, pos_inc;
  logic [EthTypeW-1:0] eth_q, eth_d;
  logic [AddrW-1:0]    src_q, src_d;
  logic [AddrW-1:0]    dst_q, dst_d;
  logic [QueueW-1:0]   frame_queue_q;
  logic                fq_bound_q;

  logic [QUEUES-1:0]   bound_q;
  logic [CounterW-1:0] cnt_q [NumCounters];

  logic [31:0]         rule_ext, queue_ext;
  logic [RuleW-1:0]    src_rd_data, dst_rd_data;
  logic [AddrW-1:0]    src_net, src_rmask, dst_net, dst_rmask;

  reason_e             reason;
  cnt_sel_e            cnt_idx;
  logic [CounterW-1:0] cnt_value;

  logic                out_valid_q;
  logic                kind_q, redirect_q;
  logic [QueueW-1:0]   rq_q;
  logic [ReasonW-1:0]  reason_q;
  logic [CounterW-1:0] value_q;

  // Configuration and effective rule counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_count_q <= '0;
      dst_count_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_SRC_COUNT: src_count_q <= cfg_data_i;
        REG_DST_COUNT: dst_count_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  always_comb begin
    if (32'(src_count_q) > SRC_RULES) begin
      src_eff = RuleCntW'(SRC_RULES);
    end else begin
      src_eff = RuleCntW'(src_count_q);
    end
    if (32'(dst_count_q) > DST_RULES) begin
      dst_eff = RuleCntW'(DST_RULES);
    end else begin
      dst_eff = RuleCntW'(dst_count_q);
    end
  end

  // Header capture
  always_comb begin
    pos_inc = (pos_q == PosMax) ? PosMax : pos_q + 1'b1;
    eth_d   = eth_q;
    src_d   = src_q;
    dst_d   = dst_q;
    if (pos_q == PosEthHi || pos_q == PosEthLo) begin
      eth_d = {eth_q[EthTypeW-ByteW-1:0], data_byte_i};
    end else if (pos_q >= PosSrcFirst && pos_q <= PosSrcLast) begin
      src_d = {src_q[AddrW-ByteW-1:0], data_byte_i};
    end else if (pos_q >= PosDstFirst && pos_q <= PosDstLast) begin
      dst_d = {dst_q[AddrW-ByteW-1:0], data_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      eth_q <= '0;
      src_q <= '0;
      dst_q <= '0;
    end else if (cmd_i.capture) begin
      pos_q <= last_byte_i ? '0 : pos_inc;
      eth_q <= eth_d;
      src_q <= src_d;
      dst_q <= dst_d;
    end
  end

  // Latch the frame queue and its binding on the final byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && last_byte_i) begin
      frame_queue_q <= queue_index_i;
      fq_bound_q    <= (queue_ext < QUEUES) && bound_q[queue_ext[QueueAw-1:0]];
    end
  end

  // Rule tables
  assign rule_ext = 32'(rule_index_i);

  icrc_ram #(
    .Width (RuleW),
    .Depth (SRC_RULES)
  ) u_src_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.src_wr && (rule_ext < SRC_RULES)),
    .wr_addr_i (rule_ext[SrcAw-1:0]),
    .wr_data_i ({rule_net_i, rule_mask_i}),
    .rd_en_i   (cmd_i.src_rd),
    .rd_addr_i (idx_q[SrcAw-1:0]),
    .rd_data_o (src_rd_data)
  );

  icrc_ram #(
    .Width (RuleW),
    .Depth (DST_RULES)
  ) u_dst_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.dst_wr && (rule_ext < DST_RULES)),
    .wr_addr_i (rule_ext[DstAw-1:0]),
    .wr_data_i ({rule_net_i, rule_mask_i}),
    .rd_en_i   (cmd_i.dst_rd),
    .rd_addr_i (idx_q[DstAw-1:0]),
    .rd_data_o (dst_rd_data)
  );

  assign src_net   = src_rd_data[RuleW-1:AddrW];
  assign src_rmask = src_rd_data[AddrW-1:0];
  assign dst_net   = dst_rd_data[RuleW-1:AddrW];
  assign dst_rmask = dst_rd_data[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Queue bindings
  assign queue_ext = 32'(queue_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '0;
    end else if (cmd_i.bind_wr && (queue_ext < QUEUES)) begin
      bound_q[queue_ext[QueueAw-1:0]] <= bind_flag_i;
    end
  end

  // Verdict and event counters
  always_comb begin
    case (cmd_i.verdict)
      V_SHORT:   reason = RSN_NOT_IPV4;
      V_NOMATCH: reason = RSN_NO_MATCH;
      V_MATCH:   reason = fq_bound_q ? RSN_REDIRECT : RSN_UNBOUND;
      default:   reason = RSN_NOT_IPV4;
    endcase
    cnt_idx = reason_to_cnt(reason);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCounters; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (cmd_i.verdict_ld) begin
      for (int k = 0; k < NumCounters; k++) begin
        if (k == int'(CNT_TOTAL) || k == int'(cnt_idx)) begin
          cnt_q[k] <= cnt_q[k] + 1'b1;
        end
      end
    end
  end

  assign cnt_value = (int'(counter_select_i) < NumCounters) ? cnt_q[counter_select_i] : '0;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.verdict_ld || cmd_i.cnt_rd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.verdict_ld) begin
      kind_q     <= KIND_VERDICT;
      redirect_q <= (reason == RSN_REDIRECT);
      rq_q       <= (reason == RSN_REDIRECT) ? frame_queue_q : '0;
      reason_q   <= reason;
      value_q    <= '0;
    end else if (cmd_i.cnt_rd) begin
      kind_q     <= KIND_COUNTER;
      redirect_q <= 1'b0;
      rq_q       <= '0;
      reason_q   <= '0;
      value_q    <= cnt_value;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign redirect_o       = redirect_q;
  assign redirect_queue_o = rq_q;
  assign reason_o         = reason_q;
  assign counter_value_o  = value_q;

  // Status
  always_comb begin
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.frame_bad = (pos_inc < MinFrameLen) || (eth_d != EthIpv4);
    sts_o.src_empty = (src_eff == '0);
    sts_o.dst_empty = (dst_eff == '0);
    sts_o.src_hit   = ((src_q & src_rmask) == (src_net & src_rmask));
    sts_o.dst_hit   = ((dst_q & dst_rmask) == (dst_net & dst_rmask));
    sts_o.src_last  = ((idx_q + 1'b1) == src_eff);
    sts_o.dst_last  = ((idx_q + 1'b1) == dst_eff);
  end

endmodule

// ===== hw/rtl/ipv4_cidr_redirect_classifier_core.sv =====
// Top level of the IPv4 CIDR redirect classifier: controller plus datapath.
// Depends on icrc_pkg, the icrc_*_if interfaces, icrc_ctrl and icrc_dp.
//
//   Channel  Dir  Handshake     Word
//   in_i     in   valid/ready   func, frame byte, rule, bind or counter select
//   res_o    out  valid/ready   verdict or counter value, one per final byte/read
//   cfg_i    in   valid/ready   register index, rule count (always ready)
//
// Frame bytes, rule writes, binds and counter reads complete on acceptance.
// A final byte of a short or non-IPv4 frame gives its verdict in that cycle;
// an IPv4 frame scans source rules up to the first hit, then destination
// rules, each read in a RD state and compared in a CMP state, then verdicts.
// The single registered read port of each rule RAM sets the scan length.
// Input stalls during a scan, and whenever a result word waits untaken.
// Reset clears counters, bindings and captures at once; rule RAMs stay unset.

module ipv4_cidr_redirect_classifier_core (
  input logic       clk_i,
  input logic       rst_ni,
  icrc_in_if.sink   in_i,
  icrc_out_if.source res_o,
  icrc_cfg_if.sink  cfg_i
);
  import icrc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  icrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .func_i     (func_e'(in_i.func)),
    .last_i     (in_i.last_byte),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  icrc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .data_byte_i      (in_i.data_byte),
    .last_byte_i      (in_i.last_byte),
    .queue_index_i    (in_i.queue_index),
    .rule_index_i     (in_i.rule_index),
    .rule_net_i       (in_i.rule_net),
    .rule_mask_i      (in_i.rule_mask),
    .bind_flag_i      (in_i.bind_flag),
    .counter_select_i (in_i.counter_select),
    .cfg_we_i         (cfg_i.valid && cfg_i.ready),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .result_kind_o    (res_o.result_kind),
    .redirect_o       (res_o.redirect),
    .redirect_queue_o (res_o.redirect_queue),
    .reason_o         (res_o.reason),
    .counter_value_o  (res_o.counter_value)
  );

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.verdict_ld || cmd.cnt_rd) |-> sts.out_free)
    else $error("result loaded over an untaken word");

  a_one_word_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.src_wr, cmd.dst_wr, cmd.bind_wr, cmd.cnt_rd}))
    else $error("more than one input operation in a cycle");

  a_scan_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.src_rd || cmd.dst_rd) |=> !in_i.ready)
    else $error("input taken during rule compare");

  a_index_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.idx_clr && cmd.idx_inc))
    else $error("rule index cleared and advanced together");

endmodule
